// ===== rtl/core/brl_pkg.sv =====
// shared types and constants for the line rasterizer
`timescale 1ns / 1ps

package brl_pkg;

   // widest tile the port fields can carry
   localparam int COORD_W = 6;
   localparam int KIND_W = 2;
   // error term for the widest tile: two bits above the coordinate width
   localparam int ERR_W = COORD_W + 2;

   localparam int DEF_COORD_BITS = COORD_W;

   // segments buffered between the front and the walker
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [KIND_W-1:0]  pixel_kind;
   } brl_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pix_x;
      logic [COORD_W-1:0] pix_y;
      logic [KIND_W-1:0]  pix_kind;
      logic               last_pixel;
   } brl_rsp_type;

   // classified segment handed from the front to the walker
   typedef struct packed {
      logic [COORD_W-1:0]      start_x;
      logic [COORD_W-1:0]      start_y;
      logic [COORD_W-1:0]      end_x;
      logic [COORD_W-1:0]      end_y;
      logic [COORD_W-1:0]      span_x;
      logic [COORD_W-1:0]      span_y;
      logic                    dir_x_negative;
      logic                    dir_y_negative;
      logic signed [ERR_W-1:0] error_init;
      logic [KIND_W-1:0]       kind;
   } brl_seg_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
   } brl_queue_status_type;

   typedef struct packed {
      logic busy;
   } brl_walk_status_type;

endpackage

// ===== rtl/core/brl_front.sv =====
// front end: masks the endpoints and works out spans, directions and initial error
`timescale 1ns / 1ps

module brl_front import brl_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic        req_valid,
   output logic        req_ready,
   input  brl_req_type req_data,
   output logic        seg_valid,
   input  logic        seg_ready,
   output brl_seg_type seg
);

   localparam int CW = COORD_BITS;
   localparam int EW = COORD_BITS + 2;

   logic [CW-1:0]          x0, y0, x1, y1;
   logic [CW-1:0]          dx, dy;
   logic signed [EW-1:0]   err0;

   always_comb begin
      x0 = req_data.start_x[CW-1:0];
      y0 = req_data.start_y[CW-1:0];
      x1 = req_data.end_x[CW-1:0];
      y1 = req_data.end_y[CW-1:0];
      dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
      dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);
      err0 = $signed({2'b00, dx}) - $signed({2'b00, dy});

      seg.start_x = COORD_W'(x0);
      seg.start_y = COORD_W'(y0);
      seg.end_x = COORD_W'(x1);
      seg.end_y = COORD_W'(y1);
      seg.span_x = COORD_W'(dx);
      seg.span_y = COORD_W'(dy);
      // equal coordinates count as a negative step, the axis never moves anyway
      seg.dir_x_negative = !(x0 < x1);
      seg.dir_y_negative = !(y0 < y1);
      seg.error_init = ERR_W'(err0);
      seg.kind = req_data.pixel_kind;
   end

   assign seg_valid = req_valid;
   assign req_ready = seg_ready;

endmodule

// ===== rtl/core/brl_queue.sv =====
// short fifo of classified segments between front and walker
`timescale 1ns / 1ps

module brl_queue import brl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  brl_seg_type          push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output brl_seg_type          pop_data,
   output brl_queue_status_type status
);

   brl_seg_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_W'(1);
   endfunction

   always_comb begin
      push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
      pop_valid = (count_ff != '0);
      push = push_valid && push_ready;
      pop = pop_valid && pop_ready;
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
      pop_data = entry_ff[rd_ptr_ff];
      status.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/brl_walker.sv =====
// back end: bresenham walk, one pixel per cycle into the output register while that register is free
`timescale 1ns / 1ps

module brl_walker import brl_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                seg_valid,
   output logic                seg_ready,
   input  brl_seg_type         seg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output brl_rsp_type         rsp_data,
   output brl_walk_status_type status
);

   localparam int CW = COORD_BITS;
   localparam int EW = COORD_BITS + 2;

   logic                 busy_ff, busy_in;
   logic [CW-1:0]        walk_x_ff, walk_x_in;
   logic [CW-1:0]        walk_y_ff, walk_y_in;
   logic [CW-1:0]        target_x_ff, target_x_in;
   logic [CW-1:0]        target_y_ff, target_y_in;
   logic [CW-1:0]        span_x_ff, span_x_in;
   logic [CW-1:0]        span_y_ff, span_y_in;
   logic                 dir_x_neg_ff, dir_x_neg_in;
   logic                 dir_y_neg_ff, dir_y_neg_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   brl_rsp_type          rsp_data_ff, rsp_data_in;

   logic                 out_free, at_end, emit, load;
   logic signed [EW:0]   e2, neg_dy, dx_wide;
   logic signed [EW-1:0] dx_e, dy_e;
   logic                 step_x, step_y;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      at_end = (walk_x_ff == target_x_ff) && (walk_y_ff == target_y_ff);
      emit = busy_ff && out_free;
      // next segment loads in the cycle the end pixel goes out
      seg_ready = !busy_ff || (emit && at_end);
      load = seg_valid && seg_ready;

      e2 = $signed({err_ff, 1'b0});
      dx_wide = $signed({3'b000, span_x_ff});
      neg_dy = -$signed({3'b000, span_y_ff});
      dx_e = $signed({2'b00, span_x_ff});
      dy_e = $signed({2'b00, span_y_ff});
      step_x = (e2 > neg_dy);
      step_y = (e2 < dx_wide);

      busy_in = busy_ff;
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      span_x_in = span_x_ff;
      span_y_in = span_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in = err_ff;
      kind_in = kind_ff;

      if (load) begin
         busy_in = 1'b1;
         walk_x_in = seg.start_x[CW-1:0];
         walk_y_in = seg.start_y[CW-1:0];
         target_x_in = seg.end_x[CW-1:0];
         target_y_in = seg.end_y[CW-1:0];
         span_x_in = seg.span_x[CW-1:0];
         span_y_in = seg.span_y[CW-1:0];
         dir_x_neg_in = seg.dir_x_negative;
         dir_y_neg_in = seg.dir_y_negative;
         err_in = seg.error_init[EW-1:0];
         kind_in = seg.kind;
      end else if (emit && at_end) begin
         busy_in = 1'b0;
      end else if (emit) begin
         if (step_x) begin
            err_in = err_in - dy_e;
            walk_x_in = dir_x_neg_ff ? (walk_x_ff - CW'(1)) : (walk_x_ff + CW'(1));
         end
         if (step_y) begin
            err_in = err_in + dx_e;
            walk_y_in = dir_y_neg_ff ? (walk_y_ff - CW'(1)) : (walk_y_ff + CW'(1));
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.pix_x = COORD_W'(walk_x_ff);
         rsp_data_in.pix_y = COORD_W'(walk_y_ff);
         rsp_data_in.pix_kind = kind_ff;
         rsp_data_in.last_pixel = at_end;
      end

      rsp_valid = rsp_valid_ff;
      rsp_data = rsp_data_ff;
      status.busy = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_x_ff <= walk_x_in;
      walk_y_ff <= walk_y_in;
      target_x_ff <= target_x_in;
      target_y_ff <= target_y_in;
      span_x_ff <= span_x_in;
      span_y_ff <= span_y_in;
      dir_x_neg_ff <= dir_x_neg_in;
      dir_y_neg_ff <= dir_y_neg_in;
      err_ff <= err_in;
      kind_ff <= kind_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/core/bresenham_line_rasterizer_top.sv =====
// Line rasterizer: each req beat is one segment (start, end, kind) inside a
// 2^COORD_BITS square tile; the block returns max(|dx|,|dy|)+1 rsp beats, one per
// pixel from start to end, the end pixel flagged by last_pixel. Endpoint bits
// above COORD_BITS are ignored. The walker takes one error-term step per cycle
// while the rsp side takes every beat, one pixel per step; a segment has 1 to
// 2^COORD_BITS pixels. The next segment loads in the cycle the previous end pixel
// is emitted, so consecutive segments run without a gap. A two-entry queue behind
// the front end takes new segments while the walker is busy.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_top import brl_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  brl_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output brl_rsp_type rsp_data
);

   logic                 front_valid, front_ready;
   brl_seg_type          front_seg;
   logic                 queue_valid, queue_ready;
   brl_seg_type          queue_seg;
   brl_queue_status_type queue_status;
   brl_walk_status_type  walk_status;

   brl_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .seg_valid(front_valid),
      .seg_ready(front_ready),
      .seg      (front_seg)
   );

   brl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(front_valid),
      .push_ready(front_ready),
      .push_data (front_seg),
      .pop_valid (queue_valid),
      .pop_ready (queue_ready),
      .pop_data  (queue_seg),
      .status    (queue_status)
   );

   brl_walker #(
      .COORD_BITS(COORD_BITS)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .seg_valid(queue_valid),
      .seg_ready(queue_ready),
      .seg      (queue_seg),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .status   (walk_status)
   );

   // a busy walker with a free output register must produce a beat
   a_walk_progress: assert property (@(posedge clock) disable iff (reset)
      (walk_status.busy && rsp_ready) |=> rsp_valid)
      else $error("walker stalled with output register free");

   // queue occupancy never exceeds its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("segment queue overflow");

   // an accepted segment is held in the queue on the next cycle
   a_queue_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (queue_status.count != '0))
      else $error("accepted segment missing from queue");

endmodule
